@@ rtl/mfp_pkg.sv @@
`default_nettype none

package mfp_pkg;

   // Message layout.
   localparam int HEADER_BYTES = 6;
   localparam logic [2:0] HEADER_LAST_POS = 3'(HEADER_BYTES - 1);

   // Result beat width on the master side, padded to whole bytes.
   localparam int RSP_DATA_W = 88;
   localparam int RSP_USED_W = 83;

   // Parser phase.
   typedef enum logic [1:0] {
      PHASE_HEADER,
      PHASE_LENGTH,
      PHASE_DATA,
      PHASE_TRAIL
   } phase_type;

   // Result kind, carried on tuser.
   typedef enum logic [2:0] {
      KIND_HEADER = 3'd0,
      KIND_DATA   = 3'd1,
      KIND_EMPTY  = 3'd2,
      KIND_DONE   = 3'd3,
      KIND_ERROR  = 3'd4
   } kind_type;

   // Error codes.
   localparam logic [1:0] ERR_HEADER_SHORT   = 2'd0;
   localparam logic [1:0] ERR_MISSING_LENGTH = 2'd1;
   localparam logic [1:0] ERR_FIELD_OVERRUN  = 2'd2;

   // One result item.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] packet_id;
      logic [7:0]  msg_type;
      logic [7:0]  sender;
      logic [7:0]  receiver;
      logic [7:0]  field_count;
      logic [7:0]  field_index;
      logic [7:0]  data_byte;
      logic        field_end;
      logic [1:0]  error_code;
      logic [15:0] frame_length;
      logic        last;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/message_frame_parser.sv @@
`default_nettype none

// Byte-stream parser for length-prefixed message frames. Each req beat carries one buffer
// byte, with tlast on the buffer's final byte. The first six bytes are the header (packet
// id low byte first, type, sender, receiver, field count); each announced field follows as
// a length byte and its payload. Results leave on rsp: tuser gives the kind, tlast marks
// the final result caused by one input byte. Results are registered in the output buffer as
// their byte is taken. With the receiver ready, the parser takes one byte per cycle while
// every byte causes at most one result; a byte that causes two results (header, data byte
// or empty field with done or error) stalls the input, as req_tready drops for a cycle
// while the second result drains from the three-slot output buffer. req_tready depends
// only on registered state, so nothing combinational runs from rsp_tready to req_tready.
module message_frame_parser (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // in_byte
   input  wire logic                            req_tlast,   // end_of_buffer
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // packet_id[15:0], msg_type[23:16], sender[31:24], receiver[39:32],
   // field_count[47:40], field_index[55:48], data_byte[63:56], field_end[64],
   // error_code[66:65], frame_length[82:67], zero padding above
   output logic [mfp_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [2:0]                           rsp_tuser,   // kind
   output logic                                 rsp_tlast    // last
);

   // Parser state.
   mfp_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  header_pos_ff, header_pos_in;
   logic [15:0] id_ff, id_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  sender_ff, sender_in;
   logic [7:0]  receiver_ff, receiver_in;
   logic [7:0]  fields_left_ff, fields_left_in;
   logic [7:0]  current_field_ff, current_field_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] length_count_ff, length_count_in;

   // Output buffer: slot 0 is the presented result.
   mfp_pkg::result_type slot0_ff, slot0_in, slot1_ff, slot1_in, slot2_ff, slot2_in;
   logic [1:0] count_ff, count_in;
   logic [1:0] count_kept;

   // Results of the byte being accepted.
   mfp_pkg::result_type res0, res1;
   logic [1:0] res_count;

   logic       req_accept;
   logic       rsp_accept;
   logic [7:0] in_byte;
   logic       eob;
   logic       hdr_last;
   logic       byte_zero;
   logic [7:0] fl_dec;
   logic [7:0] bl_dec;
   logic [15:0] len_inc;

   assign in_byte    = req_tdata;
   assign eob        = req_tlast;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff <= 2'd1);
   assign req_accept = req_tvalid && req_tready;

   // Shared conditions for the phase and datapath logic.
   assign hdr_last  = (header_pos_ff == mfp_pkg::HEADER_LAST_POS);
   assign byte_zero = (in_byte == 8'd0);
   assign fl_dec    = fields_left_ff - 8'd1;
   assign bl_dec    = bytes_left_ff - 8'd1;
   assign len_inc   = length_count_ff + 16'd1;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         mfp_pkg::PHASE_HEADER: begin
            if (hdr_last) begin
               phase_in = byte_zero ? mfp_pkg::PHASE_TRAIL : mfp_pkg::PHASE_LENGTH;
            end
         end
         mfp_pkg::PHASE_LENGTH: begin
            if (!byte_zero) begin
               phase_in = mfp_pkg::PHASE_DATA;
            end else if (fl_dec == 8'd0) begin
               phase_in = mfp_pkg::PHASE_TRAIL;
            end
         end
         mfp_pkg::PHASE_DATA: begin
            if (bl_dec == 8'd0) begin
               phase_in = (fl_dec == 8'd0) ? mfp_pkg::PHASE_TRAIL : mfp_pkg::PHASE_LENGTH;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
      if (eob) begin
         phase_in = mfp_pkg::PHASE_HEADER;
      end
   end

   // Datapath updates and the results of this byte.
   always_comb begin
      header_pos_in    = header_pos_ff;
      id_in            = id_ff;
      type_in          = type_ff;
      sender_in        = sender_ff;
      receiver_in      = receiver_ff;
      fields_left_in   = fields_left_ff;
      current_field_in = current_field_ff;
      bytes_left_in    = bytes_left_ff;
      length_count_in  = length_count_ff;
      res0             = '0;
      res1             = '0;
      res_count        = 2'd0;

      case (phase_ff)
         mfp_pkg::PHASE_HEADER: begin
            length_count_in = len_inc;
            case (header_pos_ff)
               3'd0: id_in[7:0]  = in_byte;
               3'd1: id_in[15:8] = in_byte;
               3'd2: type_in     = in_byte;
               3'd3: sender_in   = in_byte;
               3'd4: receiver_in = in_byte;
               default: begin
               end
            endcase
            if (!hdr_last) begin
               header_pos_in = header_pos_ff + 3'd1;
               if (eob) begin
                  res0.kind       = mfp_pkg::KIND_ERROR;
                  res0.error_code = mfp_pkg::ERR_HEADER_SHORT;
                  res_count       = 2'd1;
               end
            end else begin
               fields_left_in   = in_byte;
               current_field_in = 8'd0;
               res0.kind        = mfp_pkg::KIND_HEADER;
               res0.packet_id   = id_ff;
               res0.msg_type    = type_ff;
               res0.sender      = sender_ff;
               res0.receiver    = receiver_ff;
               res0.field_count = in_byte;
               res_count        = 2'd1;
               if (byte_zero) begin
                  res1.kind         = mfp_pkg::KIND_DONE;
                  res1.frame_length = len_inc;
                  res_count         = 2'd2;
               end else if (eob) begin
                  res1.kind       = mfp_pkg::KIND_ERROR;
                  res1.error_code = mfp_pkg::ERR_MISSING_LENGTH;
                  res_count       = 2'd2;
               end
            end
         end
         mfp_pkg::PHASE_LENGTH: begin
            length_count_in = len_inc;
            if (byte_zero) begin
               res0.kind        = mfp_pkg::KIND_EMPTY;
               res0.field_index = current_field_ff;
               res_count        = 2'd1;
               fields_left_in   = fl_dec;
               current_field_in = current_field_ff + 8'd1;
               if (fl_dec == 8'd0) begin
                  res1.kind         = mfp_pkg::KIND_DONE;
                  res1.frame_length = len_inc;
                  res_count         = 2'd2;
               end else if (eob) begin
                  res1.kind       = mfp_pkg::KIND_ERROR;
                  res1.error_code = mfp_pkg::ERR_MISSING_LENGTH;
                  res_count       = 2'd2;
               end
            end else begin
               bytes_left_in = in_byte;
               if (eob) begin
                  res0.kind       = mfp_pkg::KIND_ERROR;
                  res0.error_code = mfp_pkg::ERR_FIELD_OVERRUN;
                  res_count       = 2'd1;
               end
            end
         end
         mfp_pkg::PHASE_DATA: begin
            length_count_in  = len_inc;
            bytes_left_in    = bl_dec;
            res0.kind        = mfp_pkg::KIND_DATA;
            res0.field_index = current_field_ff;
            res0.data_byte   = in_byte;
            res0.field_end   = (bl_dec == 8'd0);
            res_count        = 2'd1;
            if (bl_dec == 8'd0) begin
               fields_left_in   = fl_dec;
               current_field_in = current_field_ff + 8'd1;
               if (fl_dec == 8'd0) begin
                  res1.kind         = mfp_pkg::KIND_DONE;
                  res1.frame_length = len_inc;
                  res_count         = 2'd2;
               end else if (eob) begin
                  res1.kind       = mfp_pkg::KIND_ERROR;
                  res1.error_code = mfp_pkg::ERR_MISSING_LENGTH;
                  res_count       = 2'd2;
               end
            end else if (eob) begin
               res1.kind       = mfp_pkg::KIND_ERROR;
               res1.error_code = mfp_pkg::ERR_FIELD_OVERRUN;
               res_count       = 2'd2;
            end
         end
         default: begin
            // Trailing bytes after a finished message cause nothing.
         end
      endcase

      // Mark the final result of this byte.
      if (res_count == 2'd1) begin
         res0.last = 1'b1;
      end else if (res_count == 2'd2) begin
         res1.last = 1'b1;
      end

      // The buffer end starts the next message afresh.
      if (eob) begin
         header_pos_in    = 3'd0;
         fields_left_in   = 8'd0;
         current_field_in = 8'd0;
         bytes_left_in    = 8'd0;
         length_count_in  = 16'd0;
      end
   end

   // Parser state registers, updated on each accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= mfp_pkg::PHASE_HEADER;
         header_pos_ff    <= 3'd0;
         id_ff            <= 16'd0;
         type_ff          <= 8'd0;
         sender_ff        <= 8'd0;
         receiver_ff      <= 8'd0;
         fields_left_ff   <= 8'd0;
         current_field_ff <= 8'd0;
         bytes_left_ff    <= 8'd0;
         length_count_ff  <= 16'd0;
      end else if (req_accept) begin
         phase_ff         <= phase_in;
         header_pos_ff    <= header_pos_in;
         id_ff            <= id_in;
         type_ff          <= type_in;
         sender_ff        <= sender_in;
         receiver_ff      <= receiver_in;
         fields_left_ff   <= fields_left_in;
         current_field_ff <= current_field_in;
         bytes_left_ff    <= bytes_left_in;
         length_count_ff  <= length_count_in;
      end
   end

   // Output buffer. The departing result shifts the queue down first; a beat is only
   // accepted with at most one result left behind, so its results land in the slots
   // just above those still waiting.
   always_comb begin
      slot0_in   = slot0_ff;
      slot1_in   = slot1_ff;
      slot2_in   = slot2_ff;
      count_kept = count_ff;
      if (rsp_accept) begin
         slot0_in   = slot1_ff;
         slot1_in   = slot2_ff;
         count_kept = count_ff - 2'd1;
      end
      count_in = count_kept;
      if (req_accept) begin
         count_in = count_kept + res_count;
         case (count_kept)
            2'd0: begin
               slot0_in = res0;
               slot1_in = res1;
            end
            2'd1: begin
               slot1_in = res0;
               slot2_in = res1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      slot2_ff <= slot2_in;
   end

   // Master-side payload.
   assign rsp_tdata = {(mfp_pkg::RSP_DATA_W - mfp_pkg::RSP_USED_W)'(0),
                       slot0_ff.frame_length, slot0_ff.error_code, slot0_ff.field_end,
                       slot0_ff.data_byte, slot0_ff.field_index, slot0_ff.field_count,
                       slot0_ff.receiver, slot0_ff.sender, slot0_ff.msg_type,
                       slot0_ff.packet_id};
   assign rsp_tuser = slot0_ff.kind;
   assign rsp_tlast = slot0_ff.last;

   // A beat is taken only when there is room for both of its possible results.
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (count_ff <= 2'd1))
      else $error("input beat accepted without room for its results");

   // A stalled result beat holds still until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // The newest queued result always closes the results of its byte.
   a_tail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((count_ff == 2'd1) ? slot0_ff.last :
                      (count_ff == 2'd2) ? slot1_ff.last : slot2_ff.last))
      else $error("newest queued result not marked last");

   // Message done and errors always close the results of their byte.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (slot0_ff.kind == mfp_pkg::KIND_DONE ||
                     slot0_ff.kind == mfp_pkg::KIND_ERROR) |-> slot0_ff.last)
      else $error("done or error result not marked last");

   // The buffer end always returns the parser to the header phase.
   a_eob_restart: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> phase_ff == mfp_pkg::PHASE_HEADER && header_pos_ff == 3'd0)
      else $error("buffer end did not restart the parser");

endmodule

`default_nettype wire
